[hw/rtl/owtr_pkg.sv]
// ----------------------------------------------------------------------------
// owtr_pkg: shared types and constants for the one-wire temperature reader
// Timing register layout, result word layout and the command byte table.
// ----------------------------------------------------------------------------
package owtr_pkg;

  // Widths fixed by the register map and the result word.
  localparam int unsigned TickW   = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TempW   = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_RESET_LOW      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESENCE_WAIT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESET_RECOVERY = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SLOT_LOW       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WRITE_HOLD     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_READ_SAMPLE    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_READ_RECOVERY  = 3'd6;

  // Reset values of the timing registers, in microsecond ticks.
  localparam logic [TickW-1:0] RESET_LOW_DEF      = 12'd700;
  localparam logic [TickW-1:0] PRESENCE_WAIT_DEF  = 12'd75;
  localparam logic [TickW-1:0] RESET_RECOVERY_DEF = 12'd400;
  localparam logic [TickW-1:0] SLOT_LOW_DEF       = 12'd5;
  localparam logic [TickW-1:0] WRITE_HOLD_DEF     = 12'd60;
  localparam logic [TickW-1:0] READ_SAMPLE_DEF    = 12'd10;
  localparam logic [TickW-1:0] READ_RECOVERY_DEF  = 12'd60;

  // Bus command bytes.
  localparam logic [7:0] CMD_SKIP_ROM   = 8'hcc;
  localparam logic [7:0] CMD_CONVERT    = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hbe;

  // Timing registers as seen by the sequencer.
  typedef struct packed {
    logic [TickW-1:0] reset_low;
    logic [TickW-1:0] presence_wait;
    logic [TickW-1:0] reset_recovery;
    logic [TickW-1:0] slot_low;
    logic [TickW-1:0] write_hold;
    logic [TickW-1:0] read_sample;
    logic [TickW-1:0] read_recovery;
  } owtr_cfg_t;

  // One result word.
  typedef struct packed {
    logic             drive_enable;
    logic             drive_level;
    logic             busy;
    logic             done;
    logic             no_presence;
    logic [TempW-1:0] temperature_raw;
  } owtr_res_t;

  // Command byte sent in each step of the sequence; other steps send nothing.
  function automatic logic [7:0] step_cmd(input logic [2:0] step);
    logic [7:0] cmd;
    case (step)
      3'd1, 3'd4: cmd = CMD_SKIP_ROM;
      3'd2:       cmd = CMD_CONVERT;
      3'd5:       cmd = CMD_READ_SCRATCH;
      default:    cmd = 8'h00;
    endcase
    return cmd;
  endfunction

endpackage

[hw/rtl/owtr_seq.sv]
// ----------------------------------------------------------------------------
// owtr_seq: one-wire read sequencer
// Holds the sequence state and advances it by one word per enable. The
// result for the word is produced combinationally from the next state.
// ----------------------------------------------------------------------------
module owtr_seq
  import owtr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic       func,
  input  logic       line_level,
  input  owtr_cfg_t  cfg,
  output owtr_res_t  res
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_RLOW  = 4'd1;
  localparam logic [3:0] PH_RWAIT = 4'd2;
  localparam logic [3:0] PH_RREC  = 4'd3;
  localparam logic [3:0] PH_WLOW  = 4'd4;
  localparam logic [3:0] PH_WHOLD = 4'd5;
  localparam logic [3:0] PH_DLOW  = 4'd6;
  localparam logic [3:0] PH_DWAIT = 4'd7;
  localparam logic [3:0] PH_DREC  = 4'd8;

  localparam logic [2:0] STEP_RESET1 = 3'd0;
  localparam logic [2:0] STEP_RESET2 = 3'd3;
  localparam logic [2:0] STEP_BYTE0  = 3'd6;
  localparam logic [2:0] STEP_BYTE1  = 3'd7;

  logic [3:0]       phase_r, phase_nxt;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [TempW-1:0] result_r, result_nxt;
  logic             err_r, err_nxt;

  logic [TickW-1:0] lim;
  logic [TickW-1:0] tick_inc;
  logic             expire;
  logic             do_enter;
  logic [2:0]       enter_s;
  logic             done;
  logic [7:0]       cmd;

  // Length of the current phase.
  always_comb begin
    unique case (phase_r)
      PH_RLOW:  lim = cfg.reset_low;
      PH_RWAIT: lim = cfg.presence_wait;
      PH_RREC:  lim = cfg.reset_recovery;
      PH_WLOW:  lim = cfg.slot_low;
      PH_WHOLD: lim = cfg.write_hold;
      PH_DLOW:  lim = cfg.slot_low;
      PH_DWAIT: lim = cfg.read_sample;
      PH_DREC:  lim = cfg.read_recovery;
      default:  lim = {{(TickW-1){1'b0}}, 1'b1};
    endcase
  end

  assign tick_inc = tick_r + {{(TickW-1){1'b0}}, 1'b1};
  assign expire   = (tick_inc >= lim) || (tick_inc == '0);

  // Next state for one word.
  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    step_nxt   = step_r;
    shift_nxt  = shift_r;
    low_nxt    = low_r;
    result_nxt = result_r;
    err_nxt    = err_r;
    do_enter   = 1'b0;
    enter_s    = STEP_RESET1;
    done       = 1'b0;

    if (func) begin
      // A start is taken only when idle.
      if (phase_r == PH_IDLE) begin
        err_nxt  = 1'b0;
        do_enter = 1'b1;
        enter_s  = STEP_RESET1;
      end
    end else if (phase_r != PH_IDLE) begin
      tick_nxt = tick_inc;
      if (expire) begin
        tick_nxt = '0;
        unique case (phase_r)
          PH_RLOW: phase_nxt = PH_RWAIT;
          PH_RWAIT: begin
            if (line_level) begin
              // No presence pulse: abort with a zero result.
              err_nxt    = 1'b1;
              result_nxt = '0;
              phase_nxt  = PH_IDLE;
              step_nxt   = STEP_RESET1;
              bit_nxt    = '0;
              done       = 1'b1;
            end else begin
              phase_nxt = PH_RREC;
            end
          end
          PH_RREC: begin
            do_enter = 1'b1;
            enter_s  = step_r + 3'd1;
          end
          PH_WLOW: phase_nxt = PH_WHOLD;
          PH_DLOW: phase_nxt = PH_DWAIT;
          PH_DWAIT: begin
            shift_nxt = {line_level, shift_r[7:1]};
            phase_nxt = PH_DREC;
          end
          PH_WHOLD, PH_DREC: begin
            // End of a bit slot.
            if (bit_r != 3'd7) begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = (phase_r == PH_DREC) ? PH_DLOW : PH_WLOW;
            end else if (step_r == STEP_BYTE1) begin
              result_nxt = {shift_r, low_r};
              phase_nxt  = PH_IDLE;
              step_nxt   = STEP_RESET1;
              bit_nxt    = '0;
              done       = 1'b1;
            end else begin
              if (step_r == STEP_BYTE0) begin
                low_nxt = shift_r;
              end
              do_enter = 1'b1;
              enter_s  = step_r + 3'd1;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end

    // Entry into a new step of the sequence.
    if (do_enter) begin
      step_nxt = enter_s;
      bit_nxt  = '0;
      tick_nxt = '0;
      if (enter_s == STEP_RESET1 || enter_s == STEP_RESET2) begin
        phase_nxt = PH_RLOW;
      end else if (enter_s == STEP_BYTE0 || enter_s == STEP_BYTE1) begin
        shift_nxt = '0;
        phase_nxt = PH_DLOW;
      end else begin
        phase_nxt = PH_WLOW;
      end
    end
  end

  // Line drive and result word from the next state.
  assign cmd = step_cmd(step_nxt);

  always_comb begin
    res.drive_enable = 1'b1;
    res.drive_level  = 1'b1;
    unique case (phase_nxt)
      PH_RLOW, PH_WLOW, PH_DLOW: res.drive_level = 1'b0;
      PH_WHOLD:                  res.drive_level = cmd[bit_nxt];
      PH_DWAIT, PH_DREC:         res.drive_enable = 1'b0;
      default:                   res.drive_level = 1'b1;
    endcase
    res.busy            = (phase_nxt != PH_IDLE);
    res.done            = done;
    res.no_presence     = done && err_nxt;
    res.temperature_raw = result_nxt;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      bit_r    <= '0;
      step_r   <= '0;
      shift_r  <= '0;
      low_r    <= '0;
      result_r <= '0;
      err_r    <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      step_r   <= step_nxt;
      shift_r  <= shift_nxt;
      low_r    <= low_nxt;
      result_r <= result_nxt;
      err_r    <= err_nxt;
    end
  end

  // The tick counter rests at zero whenever the sequencer is idle.
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_r == '0)
    else $error("tick counter not cleared while idle");

  // Reset phases only occur in the two reset steps, at bit zero.
  a_reset_step: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RLOW || phase_r == PH_RWAIT || phase_r == PH_RREC) |->
      ((step_r == STEP_RESET1 || step_r == STEP_RESET2) && bit_r == '0))
    else $error("reset phase outside a reset step");

  // A finished sequence leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.done |=> phase_r == PH_IDLE)
    else $error("sequencer busy after done");

  // An abort reports a zero temperature.
  a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res.no_presence |-> (res.done && res.temperature_raw == '0))
    else $error("abort without zero result");

endmodule

[hw/rtl/one_wire_temp_sensor_reader_top.sv]
// ----------------------------------------------------------------------------
// one_wire_temp_sensor_reader_top: one-wire temperature read bus master
// Timing registers, input handshake and the registered result word.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is either a microsecond tick (in_func = 0) or a start
//   request (in_func = 1), with the sampled bus level on in_line_level.
//   Every accepted word yields exactly one result word with the bus drive
//   controls, busy/done flags, the presence error flag and the last
//   temperature scratchpad value.
//   A word accepted at one edge shows its result at the out_ port after
//   that edge. One word is taken every cycle while the receiver keeps up;
//   the rate is set by the single state update per word.
//   When out_ready is low the result register holds its word and in_ready
//   drops, so no word is lost; the state advances only on accepted words.
//   Reset returns the sequencer to idle, clears the stored temperature and
//   loads the default timing values. Timing registers are written through
//   cfg_wr_en / cfg_index / cfg_wdata, by the user only while idle; the
//   block does not check. An index outside the register list is ignored.
// ----------------------------------------------------------------------------
module one_wire_temp_sensor_reader_top
  import owtr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TickW-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic               in_line_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_drive_enable,
  output logic               out_drive_level,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic               out_no_presence,
  output logic [TempW-1:0]   out_temperature_raw
);

  owtr_cfg_t cfg_r;
  owtr_res_t res;
  owtr_res_t res_r;
  logic      out_valid_r;
  logic      in_accept;

  // A word is taken whenever the result register is free or being drained.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // Timing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low      <= RESET_LOW_DEF;
      cfg_r.presence_wait  <= PRESENCE_WAIT_DEF;
      cfg_r.reset_recovery <= RESET_RECOVERY_DEF;
      cfg_r.slot_low       <= SLOT_LOW_DEF;
      cfg_r.write_hold     <= WRITE_HOLD_DEF;
      cfg_r.read_sample    <= READ_SAMPLE_DEF;
      cfg_r.read_recovery  <= READ_RECOVERY_DEF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RESET_LOW:      cfg_r.reset_low      <= cfg_wdata;
        REG_PRESENCE_WAIT:  cfg_r.presence_wait  <= cfg_wdata;
        REG_RESET_RECOVERY: cfg_r.reset_recovery <= cfg_wdata;
        REG_SLOT_LOW:       cfg_r.slot_low       <= cfg_wdata;
        REG_WRITE_HOLD:     cfg_r.write_hold     <= cfg_wdata;
        REG_READ_SAMPLE:    cfg_r.read_sample    <= cfg_wdata;
        REG_READ_RECOVERY:  cfg_r.read_recovery  <= cfg_wdata;
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  // Sequencer.
  owtr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .func       (in_func),
    .line_level (in_line_level),
    .cfg        (cfg_r),
    .res        (res)
  );

  // Result register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_enable    = res_r.drive_enable;
  assign out_drive_level     = res_r.drive_level;
  assign out_busy_res        = res_r.busy;
  assign out_done_res        = res_r.done;
  assign out_no_presence     = res_r.no_presence;
  assign out_temperature_raw = res_r.temperature_raw;

endmodule
